/* sv/pwc_pkg.sv */
package pwc_pkg;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] vel_par;
    logic signed [31:0] vel_perp_a;
    logic signed [31:0] vel_perp_b;
    logic               exit_low_in;
    logic               exit_high_in;
    logic        [47:0] energy_low_in;
    logic        [47:0] energy_high_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] vel_par_out;
    logic               exit_low;
    logic               exit_high;
    logic        [47:0] energy_low;
    logic        [47:0] energy_high;
  } result_t;

  typedef struct packed {
    logic signed [31:0] wall_low;
    logic signed [31:0] wall_high;
    logic        [30:0] reflect_offset;
    logic        [47:0] barrier_low;
    logic        [47:0] barrier_high;
    logic        [1:0]  mode;
    logic        [31:0] mass;
    logic        [47:0] light_speed_sq;
  } cfg_t;

  typedef enum logic [3:0] {
    REG_WALL_LOW       = 4'd0,
    REG_WALL_HIGH      = 4'd1,
    REG_REFLECT_OFFSET = 4'd2,
    REG_BARRIER_LOW    = 4'd3,
    REG_BARRIER_HIGH   = 4'd4,
    REG_MODE           = 4'd5,
    REG_MASS           = 4'd6,
    REG_LIGHT_SPEED_SQ = 4'd7
  } reg_idx_e;

  // Classified particle as it leaves the front part.
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vpar;
    logic signed [31:0] pos_lo_r;
    logic signed [31:0] pos_hi_r;
    logic signed [31:0] vpar_lo_r;
    logic signed [31:0] vpar_hi_r;
    logic               f_lo;
    logic               f_hi;
    logic               hit_lo;
    logic               hit_hi;
    logic        [47:0] e_lo;
    logic        [47:0] e_hi;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] speed2;
    logic [63:0] vpar2;
  } front_t;

  localparam int MODE_SHEATH_BIT = 0;
  localparam int MODE_REL_BIT    = 1;

  localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] BETA2_MAX = 48'hFFFF_FFFF_FEE6;
  localparam logic [48:0] ONE_Q48   = 49'h1_0000_0000_0000;
  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int BUSY_LEVEL = 2;

  // Back pipeline stage map.
  localparam int B_DIV_START = 2;
  localparam int RATIO_STEPS = 32;
  localparam int SQ_INIT     = 50;
  localparam int GM_INIT     = 83;
  localparam int E_MUL       = 137;
  localparam int E_ADD       = 138;
  localparam int P_MUL       = 139;
  localparam int P_ADD       = 140;
  localparam int NSTAGE      = 141;

endpackage

/* sv/pwc_front.sv */
module pwc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  pwc_pkg::item_t  item_i,
  input  pwc_pkg::cfg_t   cfg_i,
  output logic            push_o,
  output pwc_pkg::front_t entry_o
);

  pwc_pkg::ctx_t      ctx_d, ctx_q;
  logic        [63:0] vp2_q, va2_q, vb2_q;
  logic        [31:0] abs_p, abs_a, abs_b;
  logic               vld_q;
  logic signed [32:0] lo_sum, hi_dif;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  always_comb begin
    abs_p = mag(item_i.vel_par);
    abs_a = mag(item_i.vel_perp_a);
    abs_b = mag(item_i.vel_perp_b);

    lo_sum = {cfg_i.wall_low[31], cfg_i.wall_low} + {2'b00, cfg_i.reflect_offset};
    hi_dif = {cfg_i.wall_high[31], cfg_i.wall_high} - {2'b00, cfg_i.reflect_offset};

    ctx_d.pos    = item_i.position;
    ctx_d.vpar   = item_i.vel_par;
    ctx_d.f_lo   = item_i.exit_low_in;
    ctx_d.f_hi   = item_i.exit_high_in;
    ctx_d.e_lo   = item_i.energy_low_in;
    ctx_d.e_hi   = item_i.energy_high_in;
    ctx_d.hit_lo = $signed(item_i.position) <= $signed(cfg_i.wall_low);
    ctx_d.hit_hi = $signed(item_i.position) >= $signed(cfg_i.wall_high);
    ctx_d.pos_lo_r = (lo_sum[32] != lo_sum[31]) ? 32'sh7FFF_FFFF : lo_sum[31:0];
    ctx_d.pos_hi_r = (hi_dif[32] != hi_dif[31]) ? 32'sh8000_0000 : hi_dif[31:0];
    // The most negative velocity has no positive twin and clamps.
    if (!item_i.vel_par[31]) begin
      ctx_d.vpar_lo_r = item_i.vel_par;
    end else if (item_i.vel_par == 32'sh8000_0000) begin
      ctx_d.vpar_lo_r = 32'sh7FFF_FFFF;
    end else begin
      ctx_d.vpar_lo_r = -item_i.vel_par;
    end
    ctx_d.vpar_hi_r = ($signed(item_i.vel_par) > 0) ? -item_i.vel_par : item_i.vel_par;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctx_q <= ctx_d;
      vp2_q <= 64'(abs_p) * 64'(abs_p);
      va2_q <= 64'(abs_a) * 64'(abs_a);
      vb2_q <= 64'(abs_b) * 64'(abs_b);
    end
  end

  assign push_o         = vld_q;
  assign entry_o.ctx    = ctx_q;
  assign entry_o.vpar2  = vp2_q;
  assign entry_o.speed2 = vp2_q + va2_q + vb2_q;

endmodule

/* sv/pwc_fifo.sv */
module pwc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pwc_pkg::front_t data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [pwc_pkg::FIFO_AW:0] level_o,
  output pwc_pkg::front_t data_o
);

  pwc_pkg::front_t                 mem_q [pwc_pkg::FIFO_DEPTH];
  logic [pwc_pkg::FIFO_AW-1:0]     wr_q, rd_q;
  logic [pwc_pkg::FIFO_AW:0]       cnt_q;
  logic                            do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign level_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {{pwc_pkg::FIFO_AW{1'b0}}, push_i}
                     - {{pwc_pkg::FIFO_AW{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/pwc_back.sv */
module pwc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pwc_pkg::front_t  entry_i,
  input  pwc_pkg::cfg_t    cfg_i,
  output logic             done_o,
  output pwc_pkg::result_t result_o
);

  typedef struct packed {
    pwc_pkg::ctx_t ctx;
    logic [63:0]   speed2;
    logic [63:0]   vpar2;
    logic          spd_zero;
    logic [63:0]   nf_lo;
    logic [63:0]   nf_hi;
    logic [63:0]   np_lo;
    logic [63:0]   np_hi;
    logic [63:0]   m_lo;
    logic [47:0]   m_hi;
    logic [47:0]   full_n;
    logic [47:0]   epar_n;
    logic [63:0]   mc2;
    logic          b_over;
    logic [47:0]   br;
    logic [47:0]   bq;
    logic [47:0]   bsh;
    logic [63:0]   rr;
    logic [32:0]   rq;
    logic [63:0]   sx;
    logic [34:0]   srem;
    logic [31:0]   sroot;
    logic [31:0]   s;
    logic [31:0]   gr;
    logic [52:0]   gq;
    logic [52:0]   gsh;
    logic [63:0]   e00;
    logic [63:0]   e01;
    logic [52:0]   e10;
    logic [52:0]   e11;
    logic [47:0]   full;
    logic [56:0]   p0;
    logic [56:0]   p1;
    logic [47:0]   epar;
  } work_t;

  work_t                          head;
  work_t                          pipe_q [1:pwc_pkg::NSTAGE];
  logic [pwc_pkg::NSTAGE:1]       vld_q;
  pwc_pkg::result_t               res_d, res_q;
  logic                           done_q;
  logic                           lo_ref;

  function automatic work_t step(input work_t w, input int k, input pwc_pkg::cfg_t c);
    work_t        o;
    logic [48:0]  b_t;
    logic [64:0]  r_t;
    logic [34:0]  s_t;
    logic [34:0]  s_tr;
    logic [32:0]  g_t;
    logic [31:0]  n31;
    logic [95:0]  pn;
    logic [95:0]  pp;
    logic [79:0]  pm;
    logic [47:0]  b2;
    logic [48:0]  dd;
    logic [117:0] pe;
    logic [81:0]  pq;
    logic [47:0]  fr;
    o = w;
    if (k == 0) begin
      o.nf_lo    = 64'(c.mass) * 64'(w.speed2[31:0]);
      o.nf_hi    = 64'(c.mass) * 64'(w.speed2[63:32]);
      o.np_lo    = 64'(c.mass) * 64'(w.vpar2[31:0]);
      o.np_hi    = 64'(c.mass) * 64'(w.vpar2[63:32]);
      o.m_lo     = 64'(c.mass) * 64'(c.light_speed_sq[31:0]);
      o.m_hi     = 48'(c.mass) * 48'(c.light_speed_sq[47:32]);
      o.spd_zero = (w.speed2 == 64'd0);
      // Speeds at or above light leave the divider's range and clamp.
      o.b_over   = (w.speed2[63:16] >= c.light_speed_sq);
      o.br       = w.speed2[63:16];
      o.bsh      = {w.speed2[15:0], 32'd0};
      o.bq       = '0;
      o.rq       = {32'd0, (w.vpar2 == w.speed2)};
      o.rr       = (w.vpar2 == w.speed2) ? 64'd0 : w.vpar2;
    end else if (k == 1) begin
      pn       = 96'(w.nf_lo) + {w.nf_hi, 32'd0};
      pp       = 96'(w.np_lo) + {w.np_hi, 32'd0};
      o.full_n = (|pn[95:81]) ? pwc_pkg::MASK48 : pn[80:33];
      o.epar_n = (|pp[95:81]) ? pwc_pkg::MASK48 : pp[80:33];
      pm       = 80'(w.m_lo) + {w.m_hi, 32'd0};
      o.mc2    = pm[79:16];
    end else if (k < pwc_pkg::SQ_INIT) begin
      b_t = {w.br, w.bsh[47]};
      if (b_t >= {1'b0, c.light_speed_sq}) begin
        b_t  = b_t - {1'b0, c.light_speed_sq};
        o.bq = {w.bq[46:0], 1'b1};
      end else begin
        o.bq = {w.bq[46:0], 1'b0};
      end
      o.br  = b_t[47:0];
      o.bsh = {w.bsh[46:0], 1'b0};
      if (k < pwc_pkg::B_DIV_START + pwc_pkg::RATIO_STEPS) begin
        r_t = {w.rr, 1'b0};
        if (r_t >= {1'b0, w.speed2}) begin
          r_t  = r_t - {1'b0, w.speed2};
          o.rq = {w.rq[31:0], 1'b1};
        end else begin
          o.rq = {w.rq[31:0], 1'b0};
        end
        o.rr = r_t[63:0];
      end
    end else if (k == pwc_pkg::SQ_INIT) begin
      b2 = w.b_over ? pwc_pkg::BETA2_MAX
         : ((w.bq > pwc_pkg::BETA2_MAX) ? pwc_pkg::BETA2_MAX : w.bq);
      dd      = pwc_pkg::ONE_Q48 - {1'b0, b2};
      o.sx    = {1'b0, dd, 14'd0};
      o.srem  = '0;
      o.sroot = '0;
    end else if (k < pwc_pkg::GM_INIT) begin
      s_t  = {w.srem[32:0], w.sx[63:62]};
      s_tr = {1'b0, w.sroot, 2'b01};
      if (s_t >= s_tr) begin
        s_t     = s_t - s_tr;
        o.sroot = {w.sroot[30:0], 1'b1};
      end else begin
        o.sroot = {w.sroot[30:0], 1'b0};
      end
      o.srem = s_t;
      o.sx   = {w.sx[61:0], 2'b00};
    end else if (k == pwc_pkg::GM_INIT) begin
      // The root is never below 2^11, so the top eleven numerator bits give
      // no quotient bits and seed the remainder.
      n31   = pwc_pkg::ONE_Q31 - w.sroot;
      o.s   = w.sroot;
      o.gr  = {21'd0, n31[31:21]};
      o.gsh = {n31[20:0], 32'd0};
      o.gq  = '0;
    end else if (k < pwc_pkg::E_MUL) begin
      g_t = {w.gr, w.gsh[52]};
      if (g_t >= {1'b0, w.s}) begin
        g_t  = g_t - {1'b0, w.s};
        o.gq = {w.gq[51:0], 1'b1};
      end else begin
        o.gq = {w.gq[51:0], 1'b0};
      end
      o.gr  = g_t[31:0];
      o.gsh = {w.gsh[51:0], 1'b0};
    end else if (k == pwc_pkg::E_MUL) begin
      o.e00 = 64'(w.gq[31:0]) * 64'(w.mc2[31:0]);
      o.e01 = 64'(w.gq[31:0]) * 64'(w.mc2[63:32]);
      o.e10 = 53'(w.gq[52:32]) * 53'(w.mc2[31:0]);
      o.e11 = 53'(w.gq[52:32]) * 53'(w.mc2[63:32]);
    end else if (k == pwc_pkg::E_ADD) begin
      pe = 118'(w.e00) + ((118'(w.e01) + 118'(w.e10)) << 32) + (118'(w.e11) << 64);
      fr = (|pe[117:80]) ? pwc_pkg::MASK48 : pe[79:32];
      if (!c.mode[pwc_pkg::MODE_REL_BIT]) begin
        o.full = w.full_n;
      end else if (c.light_speed_sq == 48'd0) begin
        o.full = '0;
      end else begin
        o.full = fr;
      end
    end else if (k == pwc_pkg::P_MUL) begin
      o.p0 = 57'(w.full[23:0]) * 57'(w.rq);
      o.p1 = 57'(w.full[47:24]) * 57'(w.rq);
    end else begin
      pq = 82'(w.p0) + (82'(w.p1) << 24);
      fr = (|pq[81:80]) ? pwc_pkg::MASK48 : pq[79:32];
      if (!c.mode[pwc_pkg::MODE_REL_BIT]) begin
        o.epar = w.epar_n;
      end else if (w.spd_zero) begin
        o.epar = '0;
      end else begin
        o.epar = fr;
      end
    end
    return o;
  endfunction

  always_comb begin
    head        = '0;
    head.ctx    = entry_i.ctx;
    head.speed2 = entry_i.speed2;
    head.vpar2  = entry_i.vpar2;
  end

  for (genvar k = 0; k < pwc_pkg::NSTAGE; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        pipe_q[1] <= step(head, k, cfg_i);
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        pipe_q[k+1] <= step(pipe_q[k], k, cfg_i);
      end
    end
  end

  // Wall decision: a reflection at the left wall skips the right test.
  always_comb begin
    pwc_pkg::ctx_t c;
    c = pipe_q[pwc_pkg::NSTAGE].ctx;
    lo_ref = c.hit_lo && cfg_i.mode[pwc_pkg::MODE_SHEATH_BIT]
             && (pipe_q[pwc_pkg::NSTAGE].epar < cfg_i.barrier_low);
    res_d.position_out = c.pos;
    res_d.vel_par_out  = c.vpar;
    res_d.exit_low     = c.f_lo;
    res_d.exit_high    = c.f_hi;
    res_d.energy_low   = c.e_lo;
    res_d.energy_high  = c.e_hi;
    if (c.hit_lo) begin
      if (lo_ref) begin
        res_d.position_out = c.pos_lo_r;
        res_d.vel_par_out  = c.vpar_lo_r;
        res_d.exit_low     = 1'b0;
        res_d.energy_low   = '0;
      end else begin
        res_d.exit_low   = 1'b1;
        res_d.energy_low = pipe_q[pwc_pkg::NSTAGE].full;
      end
    end
    if (!lo_ref && c.hit_hi) begin
      if (cfg_i.mode[pwc_pkg::MODE_SHEATH_BIT]
          && (pipe_q[pwc_pkg::NSTAGE].epar < cfg_i.barrier_high)) begin
        res_d.position_out = c.pos_hi_r;
        res_d.vel_par_out  = c.vpar_hi_r;
        res_d.exit_high    = 1'b0;
        res_d.energy_high  = '0;
      end else begin
        res_d.exit_high   = 1'b1;
        res_d.energy_high = pipe_q[pwc_pkg::NSTAGE].full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[pwc_pkg::NSTAGE-1:1], valid_i};
      done_q <= vld_q[pwc_pkg::NSTAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[pwc_pkg::NSTAGE]) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* sv/particle_wall_check_sheath_reflect.sv */
// An accepted particle passes the front register, queue and back pipeline, and
// its result is registered onto done_o and result_o. Throughput is one particle
// per cycle while busy is low, set by the fully pipelined dividers
// and square root. The energy path is a 141-stage back pipeline behind a
// one-stage front part and a four-entry queue; results cannot be held off.
// Reset clears the pipeline valid bits and queue and sets config to defaults.
module particle_wall_check_sheath_reflect (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pwc_pkg::item_t   item_i,
  output logic             done_o,
  output pwc_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [3:0]       cfg_index_i,
  input  logic [47:0]      cfg_data_i
);

  pwc_pkg::cfg_t                cfg_q;
  pwc_pkg::front_t              f_entry, q_entry;
  logic                         f_push;
  logic                         q_empty;
  logic [pwc_pkg::FIFO_AW:0]    q_level;
  logic                         accept;

  assign busy        = (q_level >= (pwc_pkg::FIFO_AW+1)'(pwc_pkg::BUSY_LEVEL));
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_low       <= 32'sd0;
      cfg_q.wall_high      <= 32'sd65536;
      cfg_q.reflect_offset <= '0;
      cfg_q.barrier_low    <= '0;
      cfg_q.barrier_high   <= '0;
      cfg_q.mode           <= '0;
      cfg_q.mass           <= 32'd65536;
      cfg_q.light_speed_sq <= 48'd65536;
    end else if (cfg_valid_i) begin
      unique case (pwc_pkg::reg_idx_e'(cfg_index_i))
        pwc_pkg::REG_WALL_LOW:       cfg_q.wall_low       <= cfg_data_i[31:0];
        pwc_pkg::REG_WALL_HIGH:      cfg_q.wall_high      <= cfg_data_i[31:0];
        pwc_pkg::REG_REFLECT_OFFSET: cfg_q.reflect_offset <= cfg_data_i[30:0];
        pwc_pkg::REG_BARRIER_LOW:    cfg_q.barrier_low    <= cfg_data_i;
        pwc_pkg::REG_BARRIER_HIGH:   cfg_q.barrier_high   <= cfg_data_i;
        pwc_pkg::REG_MODE:           cfg_q.mode           <= cfg_data_i[1:0];
        pwc_pkg::REG_MASS:           cfg_q.mass           <= cfg_data_i[31:0];
        pwc_pkg::REG_LIGHT_SPEED_SQ: cfg_q.light_speed_sq <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pwc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .push_o   (f_push),
    .entry_o  (f_entry)
  );

  pwc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_entry),
    .pop_i   (!q_empty),
    .empty_o (q_empty),
    .level_o (q_level),
    .data_o  (q_entry)
  );

  pwc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_empty),
    .entry_i  (q_entry),
    .cfg_i    (cfg_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* dv/tb_particle_wall_check_sheath_reflect.sv */
module tb_particle_wall_check_sheath_reflect;
  timeunit 1ns;
  timeprecision 1ps;

  class particle_scoreboard;
    pwc_pkg::cfg_t    cfg;
    pwc_pkg::result_t pending[$];
    int               errors;
    int               checked;

    function new();
      cfg = '0;
      cfg.wall_high      = 32'sd65536;
      cfg.mass           = 32'd65536;
      cfg.light_speed_sq = 48'd65536;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(pwc_pkg::reg_idx_e idx, logic [47:0] val);
      case (idx)
        pwc_pkg::REG_WALL_LOW:       cfg.wall_low       = val[31:0];
        pwc_pkg::REG_WALL_HIGH:      cfg.wall_high      = val[31:0];
        pwc_pkg::REG_REFLECT_OFFSET: cfg.reflect_offset = val[30:0];
        pwc_pkg::REG_BARRIER_LOW:    cfg.barrier_low    = val;
        pwc_pkg::REG_BARRIER_HIGH:   cfg.barrier_high   = val;
        pwc_pkg::REG_MODE:           cfg.mode           = val[1:0];
        pwc_pkg::REG_MASS:           cfg.mass           = val[31:0];
        pwc_pkg::REG_LIGHT_SPEED_SQ: cfg.light_speed_sq = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] mag_sq(logic signed [31:0] v);
      longint      x;
      logic [63:0] u;
      x = v;
      if (x < 0) x = -x;
      u = x;
      return u * u;
    endfunction

    // Product shifted down and clamped to the 48-bit energy range.
    function logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> sh;
      return (p > {80'd0, pwc_pkg::MASK48}) ? {16'd0, pwc_pkg::MASK48} : p[63:0];
    endfunction

    function logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function pwc_pkg::result_t predict_exit(pwc_pkg::item_t it);
      logic [63:0]      vpar2, speed2, full, epar, b2, d, s, gm1, mc2, ratio;
      logic [127:0]     wide;
      longint           pos, vpar, wl, wh, off;
      bit               refl;
      pwc_pkg::result_t r;
      vpar2  = mag_sq(it.vel_par);
      speed2 = vpar2 + mag_sq(it.vel_perp_a) + mag_sq(it.vel_perp_b);
      if (!cfg.mode[pwc_pkg::MODE_REL_BIT]) begin
        full = scale_sat({32'd0, cfg.mass}, speed2, 33);
        epar = scale_sat({32'd0, cfg.mass}, vpar2, 33);
      end else begin
        if (cfg.light_speed_sq == 0) begin
          full = '0;
        end else begin
          if (speed2 >= ({16'd0, cfg.light_speed_sq} << 16)) begin
            b2 = {16'd0, pwc_pkg::BETA2_MAX};
          end else begin
            wide = ({64'd0, speed2} << 32) / cfg.light_speed_sq;
            b2 = wide[63:0];
          end
          if (b2 > {16'd0, pwc_pkg::BETA2_MAX}) b2 = {16'd0, pwc_pkg::BETA2_MAX};
          d   = {15'd0, pwc_pkg::ONE_Q48} - b2;
          s   = int_root(d << 14);
          gm1 = ((64'h8000_0000 - s) << 32) / s;
          wide = ({96'd0, cfg.mass} * {80'd0, cfg.light_speed_sq}) >> 16;
          mc2  = wide[63:0];
          full = scale_sat(gm1, mc2, 32);
        end
        if (speed2 == 0) begin
          epar = '0;
        end else begin
          wide  = ({64'd0, vpar2} << 32) / speed2;
          ratio = wide[63:0];
          epar  = scale_sat(full, ratio, 32);
        end
      end

      pos  = it.position;
      vpar = it.vel_par;
      wl   = cfg.wall_low;
      wh   = cfg.wall_high;
      off  = {33'd0, cfg.reflect_offset};
      r.exit_low    = it.exit_low_in;
      r.exit_high   = it.exit_high_in;
      r.energy_low  = it.energy_low_in;
      r.energy_high = it.energy_high_in;
      refl = 1'b0;
      if (pos <= wl) begin
        if (cfg.mode[pwc_pkg::MODE_SHEATH_BIT] && epar < {16'd0, cfg.barrier_low}) begin
          pos  = clamp32(wl + off);
          vpar = clamp32(vpar < 0 ? -vpar : vpar);
          r.exit_low   = 1'b0;
          r.energy_low = '0;
          refl = 1'b1;
        end else begin
          r.exit_low   = 1'b1;
          r.energy_low = full[47:0];
        end
      end
      if (!refl && pos >= wh) begin
        if (cfg.mode[pwc_pkg::MODE_SHEATH_BIT] && epar < {16'd0, cfg.barrier_high}) begin
          pos  = clamp32(wh - off);
          vpar = vpar > 0 ? -vpar : vpar;
          r.exit_high   = 1'b0;
          r.energy_high = '0;
        end else begin
          r.exit_high   = 1'b1;
          r.energy_high = full[47:0];
        end
      end
      r.position_out = pos[31:0];
      r.vel_par_out  = vpar[31:0];
      return r;
    endfunction

    function void note_particle(pwc_pkg::item_t it);
      pending = {pending, predict_exit(it)};
    endfunction

    function void check_result(pwc_pkg::result_t got);
      pwc_pkg::result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding: %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.position_out !== want.position_out) begin
        $display("%0t: position_out expected %h actual %h", $time,
                 want.position_out, got.position_out);
        errors++;
      end
      if (got.vel_par_out !== want.vel_par_out) begin
        $display("%0t: vel_par_out expected %h actual %h", $time,
                 want.vel_par_out, got.vel_par_out);
        errors++;
      end
      if (got.exit_low !== want.exit_low) begin
        $display("%0t: exit_low expected %b actual %b", $time, want.exit_low, got.exit_low);
        errors++;
      end
      if (got.exit_high !== want.exit_high) begin
        $display("%0t: exit_high expected %b actual %b", $time, want.exit_high, got.exit_high);
        errors++;
      end
      if (got.energy_low !== want.energy_low) begin
        $display("%0t: energy_low expected %h actual %h", $time,
                 want.energy_low, got.energy_low);
        errors++;
      end
      if (got.energy_high !== want.energy_high) begin
        $display("%0t: energy_high expected %h actual %h", $time,
                 want.energy_high, got.energy_high);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 50;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  pwc_pkg::item_t   item_i;
  logic             done_o;
  pwc_pkg::result_t result_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [3:0]       cfg_index_i;
  logic [47:0]      cfg_data_i;

  particle_scoreboard sb;
  int cycles;

  particle_wall_check_sheath_reflect u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  task automatic write_reg(pwc_pkg::reg_idx_e idx, logic [47:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_cfg(pwc_pkg::cfg_t c);
    write_reg(pwc_pkg::REG_WALL_LOW, {16'd0, c.wall_low});
    write_reg(pwc_pkg::REG_WALL_HIGH, {16'd0, c.wall_high});
    write_reg(pwc_pkg::REG_REFLECT_OFFSET, {17'd0, c.reflect_offset});
    write_reg(pwc_pkg::REG_BARRIER_LOW, c.barrier_low);
    write_reg(pwc_pkg::REG_BARRIER_HIGH, c.barrier_high);
    write_reg(pwc_pkg::REG_MODE, {46'd0, c.mode});
    write_reg(pwc_pkg::REG_MASS, {16'd0, c.mass});
    write_reg(pwc_pkg::REG_LIGHT_SPEED_SQ, c.light_speed_sq);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  // The start line is left high so a burst runs back to back.
  task automatic send_particle(pwc_pkg::item_t it);
    start  = 1'b1;
    item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_particle(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    logic [47:0] v;
    v = {$urandom(), 16'($urandom())};
    return v >> $urandom_range(0, 47);
  endfunction

  function automatic logic signed [31:0] rand_vel();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = '0;
      default: begin
        v = $urandom() >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_pos();
    longint p;
    longint base;
    base = $urandom_range(0, 1) ? sb.cfg.wall_low : sb.cfg.wall_high;
    case ($urandom_range(0, 5))
      0: p = $signed($urandom());
      1: p = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      2: p = base;
      default: p = base + $signed($urandom() >> $urandom_range(8, 31));
    endcase
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic pwc_pkg::item_t make_particle(logic signed [31:0] pos,
                                                   logic signed [31:0] vp,
                                                   logic signed [31:0] va,
                                                   logic signed [31:0] vb);
    pwc_pkg::item_t it;
    it.position       = pos;
    it.vel_par        = vp;
    it.vel_perp_a     = va;
    it.vel_perp_b     = vb;
    it.exit_low_in    = 1'($urandom_range(0, 1));
    it.exit_high_in   = 1'($urandom_range(0, 1));
    it.energy_low_in  = {$urandom(), 16'($urandom())};
    it.energy_high_in = {$urandom(), 16'($urandom())};
    return it;
  endfunction

  function automatic pwc_pkg::cfg_t rand_cfg(int k);
    pwc_pkg::cfg_t c;
    c.wall_low       = -($urandom() >> $urandom_range(4, 31));
    c.wall_high      = $urandom() >> $urandom_range(4, 31);
    c.reflect_offset = 31'($urandom() >> $urandom_range(1, 31));
    c.barrier_low    = rand48();
    c.barrier_high   = rand48();
    c.mode           = 2'(k % 4);
    c.mass           = $urandom() >> $urandom_range(0, 24);
    c.light_speed_sq = rand48() | 48'd1;
    // Every third setting pushes the registers to their extremes.
    if (k % 3 == 2) begin
      c.barrier_low    = $urandom_range(0, 1) ? pwc_pkg::MASK48 : '0;
      c.barrier_high   = $urandom_range(0, 1) ? pwc_pkg::MASK48 : '0;
      c.mass           = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
      c.light_speed_sq = $urandom_range(0, 1) ? pwc_pkg::MASK48 : 48'd1;
      c.reflect_offset = 31'h7FFF_FFFF;
    end
    if (k % 5 == 4) begin
      // Crossed walls let both tests fire.
      c.wall_low  = 32'sd3 << 16;
      c.wall_high = -(32'sd3 << 16);
    end
    return c;
  endfunction

  task automatic run_directed();
    pwc_pkg::cfg_t c;
    // Reset settings: Newtonian, no sheath.
    send_particle(make_particle('0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
    send_particle(make_particle(32'sd65536, 32'sh8000_0000, 32'sh7FFF_FFFF, '0));
    send_particle(make_particle(32'sd32768, 32'sd65536, '0, '0));
    send_particle(make_particle(32'sh8000_0000, '0, '0, '0));
    drain();

    // Sheath on at the extremes of the position range with the largest barriers.
    c = '0;
    c.wall_low       = 32'sh8000_0000;
    c.wall_high      = 32'sh7FFF_FFFF;
    c.reflect_offset = 31'h7FFF_FFFF;
    c.barrier_low    = pwc_pkg::MASK48;
    c.barrier_high   = pwc_pkg::MASK48;
    c.mode           = 2'd1;
    c.mass           = 32'd65536;
    c.light_speed_sq = 48'd65536;
    load_cfg(c);
    send_particle(make_particle(32'sh8000_0000, 32'sh8000_0000, '0, '0));
    send_particle(make_particle(32'sh8000_0000, 32'sd12345, '1, '0));
    send_particle(make_particle(32'sh7FFF_FFFF, 32'sd77777, '0, '0));
    send_particle(make_particle(32'sh7FFF_FFFF, -32'sd5, '0, 32'sd9));
    drain();

    // Reflected positions that leave the Q16.16 range saturate.
    write_reg(pwc_pkg::REG_WALL_LOW, {16'd0, 32'h7FFF_FF00});
    write_reg(pwc_pkg::REG_WALL_HIGH, {16'd0, 32'h8000_0100});
    send_particle(make_particle('0, -32'sd3, '0, '0));
    send_particle(make_particle(32'sh7FFF_FFFF, 32'sd3, '0, '0));
    drain();

    // Relativistic: faster than light, zero speed, then a zero c^2.
    write_reg(pwc_pkg::REG_WALL_LOW, '0);
    write_reg(pwc_pkg::REG_WALL_HIGH, {16'd0, 32'd65536});
    write_reg(pwc_pkg::REG_MODE, 48'd3);
    write_reg(pwc_pkg::REG_LIGHT_SPEED_SQ, 48'd1);
    write_reg(pwc_pkg::REG_BARRIER_LOW, 48'd1000);
    send_particle(make_particle(-32'sd1, 32'sd65536, 32'sd65536, 32'sd65536));
    send_particle(make_particle(-32'sd1, '0, '0, '0));
    send_particle(make_particle(32'sd70000, 32'sh7FFF_FFFF, '0, '0));
    drain();
    write_reg(pwc_pkg::REG_LIGHT_SPEED_SQ, '0);
    send_particle(make_particle(-32'sd1, 32'sd100, 32'sd100, '0));
    send_particle(make_particle(32'sd70000, -32'sd100, '0, 32'sd7));
    drain();

    // Crossed walls with sheath on but a zero barrier on both sides.
    write_reg(pwc_pkg::REG_LIGHT_SPEED_SQ, pwc_pkg::MASK48);
    write_reg(pwc_pkg::REG_WALL_LOW, {16'd0, 32'd200000});
    write_reg(pwc_pkg::REG_WALL_HIGH, {16'd0, -32'sd200000});
    write_reg(pwc_pkg::REG_BARRIER_LOW, '0);
    write_reg(pwc_pkg::REG_BARRIER_HIGH, '0);
    send_particle(make_particle('0, 32'sd4000, 32'sd4000, 32'sd4000));
    send_particle(make_particle('0, -32'sd4000, '0, '0));
    drain();
  endtask

  initial begin
    int gap_max;
    int burst;
    sb          = new();
    cycles      = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int k = 0; k < NUM_PHASES; k++) begin
      load_cfg(rand_cfg(k));
      // Some settings run back to back with no gaps at all.
      gap_max = (k % 4 == 1) ? 0 : $urandom_range(1, 6);
      for (int n = 0; n < PHASE_ITEMS; n += burst) begin
        burst = $urandom_range(1, 16);
        if (burst > PHASE_ITEMS - n) burst = PHASE_ITEMS - n;
        for (int b = 0; b < burst; b++)
          send_particle(make_particle(rand_pos(), rand_vel(), rand_vel(),
                                      $urandom_range(0, 3) == 0 ? 32'sd0 : rand_vel()));
        if (gap_max > 0) begin
          start = 1'b0;
          repeat ($urandom_range(0, gap_max)) @(negedge clk_i);
        end
      end
      drain();
    end

    repeat (150) @(negedge clk_i);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Checked %0d particle results across %0d register settings,", sb.checked,
             NUM_PHASES + 6);
    $display("covering both walls, sheath reflection and both energy models.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
